/* rtl/lobm_pkg.sv */
package lobm_pkg;

	// Default sizes of the book.
	localparam int unsigned PRICE_LEVEL_COUNT = 256;
	localparam int unsigned QUEUE_DEPTH       = 16;
	localparam int unsigned POOL_SLOTS        = 1024;
	localparam int unsigned FILL_CAP          = 63;

	// Operation codes.
	localparam logic [1:0] OP_LIMIT   = 2'd0;
	localparam logic [1:0] OP_MARKET  = 2'd1;
	localparam logic [1:0] OP_CANCEL  = 2'd2;
	localparam logic [1:0] OP_REPLACE = 2'd3;

	// Status codes of the final word of an operation.
	localparam logic [2:0] ST_FILLED    = 3'd0;
	localparam logic [2:0] ST_RESTED    = 3'd1;
	localparam logic [2:0] ST_NOLIQ     = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_FILLCAP   = 3'd4;
	localparam logic [2:0] ST_CANCELLED = 3'd5;
	localparam logic [2:0] ST_NOTFOUND  = 3'd6;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] taker_client;
		logic [31:0] maker_client;
		logic [15:0] fill_quantity;
		logic [7:0]  trade_level;
		logic [2:0]  status;
		logic [15:0] remaining_quantity;
		logic [7:0]  best_bid;
		logic        bid_present;
		logic [7:0]  best_ask;
		logic        ask_present;
		logic        last;
	} lobm_res_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_PL_TOP,
		S_PL_HT,
		S_PL_Q,
		S_PL_SLOT,
		S_PL_EMIT,
		S_PL_END,
		S_PL_FULL,
		S_PL_POP,
		S_ST_EMIT,
		S_AR_START,
		S_AR_RD,
		S_AR_CHK,
		S_CN_RD,
		S_CN_CHK,
		S_RM_HTRD,
		S_RM_HT,
		S_RM_RD,
		S_RM_CMP,
		S_SH_RD,
		S_SH_WR,
		S_RM_FREE,
		S_RM_DONE
	} lobm_state_t;

endpackage

/* rtl/lobm_order_if.sv */
interface lobm_order_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] client_id;
	logic        side;
	logic [7:0]  price_level;
	logic [15:0] quantity;

	modport source (output valid, operation, client_id, side, price_level, quantity,
		input ready);
	modport sink (input valid, operation, client_id, side, price_level, quantity,
		output ready);
endinterface

/* rtl/lobm_result_if.sv */
interface lobm_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [31:0] taker_client;
	logic [31:0] maker_client;
	logic [15:0] fill_quantity;
	logic [7:0]  trade_level;
	logic [2:0]  status;
	logic [15:0] remaining_quantity;
	logic [7:0]  best_bid;
	logic        bid_present;
	logic [7:0]  best_ask;
	logic        ask_present;
	logic        last;

	modport source (output valid, result_kind, taker_client, maker_client, fill_quantity,
		trade_level, status, remaining_quantity, best_bid, bid_present, best_ask,
		ask_present, last, input ready);
	modport sink (input valid, result_kind, taker_client, maker_client, fill_quantity,
		trade_level, status, remaining_quantity, best_bid, bid_present, best_ask,
		ask_present, last, output ready);
endinterface

/* rtl/lobm_core.sv */
module lobm_core #(
	parameter int unsigned LEVELS = lobm_pkg::PRICE_LEVEL_COUNT,
	parameter int unsigned DEPTH  = lobm_pkg::QUEUE_DEPTH,
	parameter int unsigned SLOTS  = lobm_pkg::POOL_SLOTS,
	parameter int unsigned CAP    = lobm_pkg::FILL_CAP
) (
	input  logic                clk,
	input  logic                arst_n,
	lobm_order_if.sink          order,
	output lobm_pkg::lobm_res_t res,
	output logic                res_valid,
	input  logic                res_ready
);

	localparam int unsigned LW   = $clog2(LEVELS);
	localparam int unsigned QW   = $clog2(DEPTH);
	localparam int unsigned SW   = $clog2(SLOTS);
	localparam int unsigned HW   = LW + 1;
	localparam int unsigned QAW  = 1 + LW + QW;
	localparam int unsigned HTN  = 2 ** HW;
	localparam int unsigned CLRN = (SLOTS > HTN) ? SLOTS : HTN;
	localparam int unsigned CW   = $clog2(CLRN);
	localparam logic [LW:0] NONE = (LW + 1)'(LEVELS);

	function automatic logic [QW-1:0] qinc(input logic [QW-1:0] p);
		return (p == QW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [QW-1:0] qdec(input logic [QW-1:0] p);
		return (p == '0) ? QW'(DEPTH - 1) : p - 1'b1;
	endfunction

	// Memories: slot pool, free stack, level queues and head/tail pointers.
	logic [31:0]     sl_client_m [SLOTS];
	logic            sl_side_m   [SLOTS];
	logic [LW-1:0]   sl_level_m  [SLOTS];
	logic [15:0]     sl_qty_m    [SLOTS];
	logic            act_m       [SLOTS];
	logic [SW-1:0]   fs_m        [SLOTS];
	logic [2*QW-1:0] ht_m        [HTN];
	logic [SW-1:0]   q_m         [2**QAW];

	lobm_pkg::lobm_state_t state_q, state_d, ret_q;

	logic [1:0]    op_q;
	logic [31:0]   cid_q;
	logic          side_q;
	logic [LW-1:0] price_q;
	logic [15:0]   qty_q, rem_q, fq_q;
	logic [5:0]    nfill_q;
	logic          limited_q, capped_q, emptied_q, found_q;
	logic [LW-1:0] b_q, lvl_q, rm_lv_q, ar_i_q;
	logic [QW-1:0] h_q, t_q, rm_pos_q;
	logic [31:0]   maker_q;
	logic [2:0]    st_q;
	logic [LW:0]   bid_q, ask_q;
	logic [SW:0]   fc_q;
	logic [CW-1:0] clr_q;
	logic [SW-1:0] cn_i_q, slot_q;
	logic          rm_side_q, ar_side_q;

	// Read ports, data registered.
	logic [SW-1:0]   sl_raddr, fs_raddr;
	logic [HW-1:0]   ht_raddr;
	logic [QAW-1:0]  q_raddr;
	logic [31:0]     sl_client_rd;
	logic            sl_side_rd, act_rd;
	logic [LW-1:0]   sl_level_rd;
	logic [15:0]     sl_qty_rd;
	logic [SW-1:0]   fs_rdata, q_rdata;
	logic [2*QW-1:0] ht_rdata;

	// Write ports.
	logic            sl_we, sl_qty_we, act_we, act_wd, fs_we, ht_we, q_we;
	logic [SW-1:0]   sl_waddr, act_waddr, fs_waddr, fs_wd, q_wd;
	logic [15:0]     sl_qty_wd;
	logic [HW-1:0]   ht_waddr;
	logic [2*QW-1:0] ht_wd;
	logic [QAW-1:0]  q_waddr;

	logic [QW-1:0] ht_h, ht_t, t_last;
	logic [LW:0]   best_opp, ar_best;
	logic          no_cross, cap_hit, place_end, ar_end, rm_empty, push, cn_hit;
	logic [15:0]   fill, newq;
	logic [31:0]   pwide;
	logic [LW-1:0] price_in;
	logic [SW:0]   fc_m1;
	logic          accept;

	assign ht_h     = ht_rdata[2*QW-1:QW];
	assign ht_t     = ht_rdata[QW-1:0];
	assign t_last   = qdec(t_q);
	assign best_opp = side_q ? bid_q : ask_q;
	assign ar_best  = ar_side_q ? ask_q : bid_q;
	assign no_cross = side_q ? (best_opp < {1'b0, price_q}) : (best_opp > {1'b0, price_q});
	assign place_end = (rem_q == '0) || (best_opp == NONE) || (limited_q && no_cross);
	assign cap_hit  = !place_end && (nfill_q == 6'(CAP));
	assign fill     = (sl_qty_rd < rem_q) ? sl_qty_rd : rem_q;
	assign newq     = sl_qty_rd - fill;
	assign ar_end   = ar_side_q ? (ar_i_q == LW'(LEVELS - 1)) : (ar_i_q == '0);
	assign rm_empty = (h_q == (found_q ? t_last : t_q));
	assign cn_hit   = act_rd && (sl_client_rd == cid_q);
	assign fc_m1    = fc_q - 1'b1;
	assign push     = ((state_q == lobm_pkg::S_PL_SLOT) && (newq == '0)) ||
		(state_q == lobm_pkg::S_RM_FREE);
	assign pwide    = 32'(order.price_level);
	assign price_in = (pwide >= LEVELS) ? LW'(LEVELS - 1) : LW'(pwide);
	assign order.ready = (state_q == lobm_pkg::S_IDLE);
	assign accept   = order.valid && order.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			lobm_pkg::S_CLEAR: if (clr_q == CW'(CLRN - 1)) state_d = lobm_pkg::S_IDLE;
			lobm_pkg::S_IDLE: begin
				if (order.valid) begin
					if (order.operation == lobm_pkg::OP_LIMIT ||
						order.operation == lobm_pkg::OP_MARKET) begin
						state_d = lobm_pkg::S_PL_TOP;
					end else begin
						state_d = lobm_pkg::S_CN_RD;
					end
				end
			end
			lobm_pkg::S_PL_TOP: state_d = (place_end || cap_hit) ? lobm_pkg::S_PL_END
				: lobm_pkg::S_PL_HT;
			lobm_pkg::S_PL_HT: state_d = (ht_h == ht_t) ? lobm_pkg::S_AR_START
				: lobm_pkg::S_PL_Q;
			lobm_pkg::S_PL_Q: state_d = lobm_pkg::S_PL_SLOT;
			lobm_pkg::S_PL_SLOT: state_d = lobm_pkg::S_PL_EMIT;
			lobm_pkg::S_PL_EMIT: begin
				if (res_ready) state_d = emptied_q ? lobm_pkg::S_AR_START : lobm_pkg::S_PL_TOP;
			end
			lobm_pkg::S_PL_END: begin
				if (rem_q == '0 || capped_q || !limited_q || fc_q == '0) begin
					state_d = lobm_pkg::S_ST_EMIT;
				end else begin
					state_d = lobm_pkg::S_PL_FULL;
				end
			end
			lobm_pkg::S_PL_FULL: state_d = (qinc(ht_t) == ht_h) ? lobm_pkg::S_ST_EMIT
				: lobm_pkg::S_PL_POP;
			lobm_pkg::S_PL_POP: state_d = lobm_pkg::S_ST_EMIT;
			lobm_pkg::S_ST_EMIT: if (res_ready) state_d = lobm_pkg::S_IDLE;
			lobm_pkg::S_AR_START: state_d = (ar_best != {1'b0, ar_i_q}) ? ret_q
				: lobm_pkg::S_AR_RD;
			lobm_pkg::S_AR_RD: state_d = lobm_pkg::S_AR_CHK;
			lobm_pkg::S_AR_CHK: state_d = (ht_h != ht_t || ar_end) ? ret_q : lobm_pkg::S_AR_RD;
			lobm_pkg::S_CN_RD: state_d = lobm_pkg::S_CN_CHK;
			lobm_pkg::S_CN_CHK: begin
				if (cn_hit) state_d = lobm_pkg::S_RM_HTRD;
				else if (cn_i_q == SW'(SLOTS - 1)) state_d = lobm_pkg::S_ST_EMIT;
				else state_d = lobm_pkg::S_CN_RD;
			end
			lobm_pkg::S_RM_HTRD: state_d = lobm_pkg::S_RM_HT;
			lobm_pkg::S_RM_HT: state_d = lobm_pkg::S_RM_RD;
			lobm_pkg::S_RM_RD: state_d = (rm_pos_q == t_q) ? lobm_pkg::S_RM_FREE
				: lobm_pkg::S_RM_CMP;
			lobm_pkg::S_RM_CMP: begin
				if (q_rdata == slot_q) begin
					state_d = (rm_pos_q == t_last) ? lobm_pkg::S_RM_FREE : lobm_pkg::S_SH_RD;
				end else begin
					state_d = lobm_pkg::S_RM_RD;
				end
			end
			lobm_pkg::S_SH_RD: state_d = lobm_pkg::S_SH_WR;
			lobm_pkg::S_SH_WR: state_d = (qinc(rm_pos_q) == t_last) ? lobm_pkg::S_RM_FREE
				: lobm_pkg::S_SH_RD;
			lobm_pkg::S_RM_FREE: state_d = rm_empty ? lobm_pkg::S_AR_START : lobm_pkg::S_RM_DONE;
			lobm_pkg::S_RM_DONE: state_d = (op_q == lobm_pkg::OP_CANCEL) ? lobm_pkg::S_ST_EMIT
				: lobm_pkg::S_PL_TOP;
			default: state_d = lobm_pkg::S_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		sl_raddr  = '0;
		fs_raddr  = '0;
		ht_raddr  = '0;
		q_raddr   = '0;
		sl_we     = 1'b0;
		sl_qty_we = 1'b0;
		sl_waddr  = slot_q;
		sl_qty_wd = '0;
		act_we    = 1'b0;
		act_waddr = slot_q;
		act_wd    = 1'b0;
		fs_we     = 1'b0;
		fs_waddr  = fc_q[SW-1:0];
		fs_wd     = slot_q;
		ht_we     = 1'b0;
		ht_waddr  = '0;
		ht_wd     = '0;
		q_we      = 1'b0;
		q_waddr   = '0;
		q_wd      = fs_rdata;
		case (state_q)
			lobm_pkg::S_CLEAR: begin
				act_we    = (32'(clr_q) < SLOTS);
				act_waddr = clr_q[SW-1:0];
				fs_we     = (32'(clr_q) < SLOTS);
				fs_waddr  = clr_q[SW-1:0];
				fs_wd     = SW'(SLOTS - 1) - clr_q[SW-1:0];
				ht_we     = (32'(clr_q) < HTN);
				ht_waddr  = clr_q[HW-1:0];
			end
			lobm_pkg::S_PL_TOP: ht_raddr = {~side_q, best_opp[LW-1:0]};
			lobm_pkg::S_PL_HT: q_raddr = {~side_q, b_q, ht_h};
			lobm_pkg::S_PL_Q: sl_raddr = q_rdata;
			lobm_pkg::S_PL_SLOT: begin
				sl_qty_we = 1'b1;
				sl_qty_wd = newq;
				if (newq == '0) begin
					act_we   = 1'b1;
					fs_we    = (fc_q < (SW + 1)'(SLOTS));
					ht_we    = 1'b1;
					ht_waddr = {~side_q, b_q};
					ht_wd    = {qinc(h_q), t_q};
				end
			end
			lobm_pkg::S_PL_END: ht_raddr = {side_q, price_q};
			lobm_pkg::S_PL_FULL: fs_raddr = fc_m1[SW-1:0];
			lobm_pkg::S_PL_POP: begin
				sl_waddr  = fs_rdata;
				sl_we     = 1'b1;
				sl_qty_we = 1'b1;
				sl_qty_wd = rem_q;
				act_we    = 1'b1;
				act_waddr = fs_rdata;
				act_wd    = 1'b1;
				q_we      = 1'b1;
				q_waddr   = {side_q, price_q, t_q};
				ht_we     = 1'b1;
				ht_waddr  = {side_q, price_q};
				ht_wd     = {h_q, qinc(t_q)};
			end
			lobm_pkg::S_AR_RD: ht_raddr = {ar_side_q, ar_i_q};
			lobm_pkg::S_CN_RD: sl_raddr = cn_i_q;
			lobm_pkg::S_RM_HTRD: ht_raddr = {rm_side_q, rm_lv_q};
			lobm_pkg::S_RM_RD: q_raddr = {rm_side_q, rm_lv_q, rm_pos_q};
			lobm_pkg::S_SH_RD: q_raddr = {rm_side_q, rm_lv_q, qinc(rm_pos_q)};
			lobm_pkg::S_SH_WR: begin
				q_we    = 1'b1;
				q_waddr = {rm_side_q, rm_lv_q, rm_pos_q};
				q_wd    = q_rdata;
			end
			lobm_pkg::S_RM_FREE: begin
				ht_we     = found_q;
				ht_waddr  = {rm_side_q, rm_lv_q};
				ht_wd     = {h_q, t_last};
				act_we    = 1'b1;
				sl_qty_we = 1'b1;
				fs_we     = (fc_q < (SW + 1)'(SLOTS));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (sl_we) begin
			sl_client_m[sl_waddr] <= cid_q;
			sl_side_m[sl_waddr]   <= side_q;
			sl_level_m[sl_waddr]  <= price_q;
		end
		if (sl_qty_we) sl_qty_m[sl_waddr] <= sl_qty_wd;
		sl_client_rd <= sl_client_m[sl_raddr];
		sl_side_rd   <= sl_side_m[sl_raddr];
		sl_level_rd  <= sl_level_m[sl_raddr];
		sl_qty_rd    <= sl_qty_m[sl_raddr];
	end

	always_ff @(posedge clk) begin
		if (act_we) act_m[act_waddr] <= act_wd;
		act_rd <= act_m[sl_raddr];
	end

	always_ff @(posedge clk) begin
		if (fs_we) fs_m[fs_waddr] <= fs_wd;
		fs_rdata <= fs_m[fs_raddr];
	end

	always_ff @(posedge clk) begin
		if (ht_we) ht_m[ht_waddr] <= ht_wd;
		ht_rdata <= ht_m[ht_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_we) q_m[q_waddr] <= q_wd;
		q_rdata <= q_m[q_raddr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lobm_pkg::S_CLEAR;
			clr_q   <= '0;
			fc_q    <= (SW + 1)'(SLOTS);
			bid_q   <= NONE;
			ask_q   <= NONE;
		end else begin
			state_q <= state_d;
			if (state_q == lobm_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			if (push && fc_q < (SW + 1)'(SLOTS)) fc_q <= fc_q + 1'b1;
			if (state_q == lobm_pkg::S_PL_POP) begin
				fc_q <= fc_m1;
				if (side_q) begin
					if (ask_q == NONE || {1'b0, price_q} < ask_q) ask_q <= {1'b0, price_q};
				end else begin
					if (bid_q == NONE || {1'b0, price_q} > bid_q) bid_q <= {1'b0, price_q};
				end
			end
			if (state_q == lobm_pkg::S_AR_CHK) begin
				if (ht_h != ht_t) begin
					if (ar_side_q) ask_q <= {1'b0, ar_i_q};
					else bid_q <= {1'b0, ar_i_q};
				end else if (ar_end) begin
					if (ar_side_q) ask_q <= NONE;
					else bid_q <= NONE;
				end
			end
		end
	end

	// Working registers of the current operation.
	always_ff @(posedge clk) begin
		case (state_q)
			lobm_pkg::S_IDLE: begin
				if (accept) begin
					op_q      <= order.operation;
					cid_q     <= order.client_id;
					side_q    <= order.side;
					price_q   <= price_in;
					qty_q     <= order.quantity;
					rem_q     <= order.quantity;
					nfill_q   <= '0;
					capped_q  <= 1'b0;
					limited_q <= (order.operation == lobm_pkg::OP_LIMIT);
					cn_i_q    <= '0;
				end
			end
			lobm_pkg::S_PL_TOP: begin
				b_q <= best_opp[LW-1:0];
				if (cap_hit) capped_q <= 1'b1;
			end
			lobm_pkg::S_PL_HT: begin
				h_q       <= ht_h;
				t_q       <= ht_t;
				ar_side_q <= ~side_q;
				ar_i_q    <= b_q;
				ret_q     <= lobm_pkg::S_PL_TOP;
			end
			lobm_pkg::S_PL_Q: slot_q <= q_rdata;
			lobm_pkg::S_PL_SLOT: begin
				maker_q   <= sl_client_rd;
				fq_q      <= fill;
				lvl_q     <= sl_level_rd;
				rem_q     <= rem_q - fill;
				emptied_q <= (newq == '0) && (qinc(h_q) == t_q);
			end
			lobm_pkg::S_PL_EMIT: if (res_ready) nfill_q <= nfill_q + 1'b1;
			lobm_pkg::S_PL_END: begin
				if (rem_q == '0) st_q <= lobm_pkg::ST_FILLED;
				else if (capped_q) st_q <= lobm_pkg::ST_FILLCAP;
				else if (!limited_q) st_q <= lobm_pkg::ST_NOLIQ;
				else st_q <= lobm_pkg::ST_FULL;
			end
			lobm_pkg::S_PL_FULL: begin
				h_q  <= ht_h;
				t_q  <= ht_t;
				st_q <= (qinc(ht_t) == ht_h) ? lobm_pkg::ST_FULL : lobm_pkg::ST_RESTED;
			end
			lobm_pkg::S_AR_CHK: begin
				if (ar_side_q) ar_i_q <= ar_i_q + 1'b1;
				else ar_i_q <= ar_i_q - 1'b1;
			end
			lobm_pkg::S_CN_CHK: begin
				slot_q    <= cn_i_q;
				rm_side_q <= sl_side_rd;
				rm_lv_q   <= sl_level_rd;
				cn_i_q    <= cn_i_q + 1'b1;
				st_q      <= lobm_pkg::ST_NOTFOUND;
				rem_q     <= '0;
			end
			lobm_pkg::S_RM_HT: begin
				h_q      <= ht_h;
				t_q      <= ht_t;
				rm_pos_q <= ht_h;
				found_q  <= 1'b0;
			end
			lobm_pkg::S_RM_CMP: begin
				if (q_rdata == slot_q) found_q <= 1'b1;
				else rm_pos_q <= qinc(rm_pos_q);
			end
			lobm_pkg::S_SH_WR: rm_pos_q <= qinc(rm_pos_q);
			lobm_pkg::S_RM_FREE: begin
				ar_side_q <= rm_side_q;
				ar_i_q    <= rm_lv_q;
				ret_q     <= lobm_pkg::S_RM_DONE;
			end
			lobm_pkg::S_RM_DONE: begin
				if (op_q == lobm_pkg::OP_CANCEL) begin
					st_q  <= lobm_pkg::ST_CANCELLED;
					rem_q <= '0;
				end else begin
					side_q    <= rm_side_q;
					limited_q <= 1'b1;
					nfill_q   <= '0;
					capped_q  <= 1'b0;
					rem_q     <= qty_q;
				end
			end
			default: ;
		endcase
	end

	// Result word.
	always_comb begin
		res = '0;
		res.taker_client       = cid_q;
		res.remaining_quantity = rem_q;
		if (state_q == lobm_pkg::S_ST_EMIT) begin
			res.result_kind = 1'b1;
			res.status      = st_q;
			res.bid_present = (bid_q != NONE);
			res.best_bid    = (bid_q != NONE) ? 8'(32'(bid_q)) : 8'd0;
			res.ask_present = (ask_q != NONE);
			res.best_ask    = (ask_q != NONE) ? 8'(32'(ask_q)) : 8'd0;
			res.last        = 1'b1;
		end else begin
			res.maker_client  = maker_q;
			res.fill_quantity = fq_q;
			res.trade_level   = 8'(32'(lvl_q));
			res.status        = lobm_pkg::ST_FILLED;
		end
	end

	assign res_valid = (state_q == lobm_pkg::S_PL_EMIT) || (state_q == lobm_pkg::S_ST_EMIT);

endmodule

/* rtl/limit_order_book_matcher.sv */
// Price-time priority limit order book with a single matching sequencer.
// The order channel takes one word per operation (limit, market, cancel or
// replace); it is ready only while the sequencer is idle. The result channel
// returns, for each operation, one fill word per resting order touched and
// then one status word with last set, carrying the book tops after the work.
// All book storage sits in memories with a read port and a write port and
// registered reads, so each lookup has a state that issues the read and a
// state that uses the data. A level that empties starts a scan for the next
// best level. Cancel and replace first search the slot pool slot by slot,
// then walk and close up the level queue. After reset the block runs a
// clearing pass that fills the free stack and empties all queues; the
// order channel stays not ready meanwhile.
// A stalled result channel holds the sequencer in place; an output register
// lets one finished word wait while the next is being formed.
module limit_order_book_matcher #(
	parameter int unsigned PRICE_LEVEL_COUNT = lobm_pkg::PRICE_LEVEL_COUNT,
	parameter int unsigned QUEUE_DEPTH       = lobm_pkg::QUEUE_DEPTH,
	parameter int unsigned POOL_SLOTS        = lobm_pkg::POOL_SLOTS,
	parameter int unsigned FILL_CAP          = lobm_pkg::FILL_CAP
) (
	input  logic          clk,
	input  logic          arst_n,
	lobm_order_if.sink    order,
	lobm_result_if.source result
);

	lobm_pkg::lobm_res_t core_res, res_q;
	logic                core_valid, core_ready, valid_q;

	lobm_core #(
		.LEVELS (PRICE_LEVEL_COUNT),
		.DEPTH  (QUEUE_DEPTH),
		.SLOTS  (POOL_SLOTS),
		.CAP    (FILL_CAP)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.order     (order),
		.res       (core_res),
		.res_valid (core_valid),
		.res_ready (core_ready)
	);

	// The output register takes a new word whenever it is empty or being drained.
	assign core_ready = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (core_ready) begin
			valid_q <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_ready && core_valid) res_q <= core_res;
	end

	assign result.valid              = valid_q;
	assign result.result_kind        = res_q.result_kind;
	assign result.taker_client       = res_q.taker_client;
	assign result.maker_client       = res_q.maker_client;
	assign result.fill_quantity      = res_q.fill_quantity;
	assign result.trade_level        = res_q.trade_level;
	assign result.status             = res_q.status;
	assign result.remaining_quantity = res_q.remaining_quantity;
	assign result.best_bid           = res_q.best_bid;
	assign result.bid_present        = res_q.bid_present;
	assign result.best_ask           = res_q.best_ask;
	assign result.ask_present        = res_q.ask_present;
	assign result.last               = res_q.last;

endmodule

/* tb/tb_limit_order_book_matcher.sv */
`timescale 1ns / 1ps

module tb_limit_order_book_matcher;

	// Sizes of the book as the block is built by default.
	localparam int unsigned LEVELS   = lobm_pkg::PRICE_LEVEL_COUNT;
	localparam int unsigned DEPTH    = lobm_pkg::QUEUE_DEPTH;
	localparam int unsigned SLOTS    = lobm_pkg::POOL_SLOTS;
	localparam int unsigned MAX_FILL = lobm_pkg::FILL_CAP;
	// Marker for a side of the book that has no resting order.
	localparam int unsigned NO_LEVEL = LEVELS;
	// Idle cycles tolerated on both channels. The worst legitimate stretch is a
	// cancel or replace that searches the whole pool, then scans every level for
	// a new best, then walks a queue, all while the result side stalls; the
	// clearing pass after reset is shorter than that.
	localparam int unsigned IDLE_LIMIT = 20000;
	localparam int unsigned RANDOM_ORDERS = 30;

	logic clk;
	logic arst_n;

	lobm_order_if  order ();
	lobm_result_if result ();

	limit_order_book_matcher DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.order  (order.sink),
		.result (result.source)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Book model. Orders live in a pool of slots handed out from a free
	// stack; each level of each side is a ring of slot numbers whose head
	// and tail share one packed word, exactly as the block keeps them.
	// ------------------------------------------------------------------
	int unsigned slot_owner [SLOTS];
	bit          slot_sell  [SLOTS];
	int unsigned slot_price [SLOTS];
	int unsigned slot_open  [SLOTS];
	bit          slot_live  [SLOTS];
	int unsigned free_slots [SLOTS];
	int unsigned free_depth;
	int unsigned ring       [2][LEVELS * DEPTH];
	int unsigned ring_ptrs  [2][LEVELS];
	int unsigned top_level  [2];

	// Words the block still owes, oldest first, kept by sequence number.
	lobm_pkg::lobm_res_t owed_words [int unsigned];
	int unsigned         owed_wr;
	int unsigned         owed_rd;

	int unsigned fail_count;
	int unsigned words_seen;
	int unsigned fills_seen;
	int unsigned orders_sent;
	int unsigned status_hits [8];
	logic [2:0]  last_status;

	function automatic int unsigned ring_head(int unsigned s, int unsigned lv);
		return (ring_ptrs[s][lv] / DEPTH) % DEPTH;
	endfunction

	function automatic int unsigned ring_tail(int unsigned s, int unsigned lv);
		return ring_ptrs[s][lv] % DEPTH;
	endfunction

	function automatic bit ring_empty(int unsigned s, int unsigned lv);
		return ring_head(s, lv) == ring_tail(s, lv);
	endfunction

	function automatic void book_clear();
		for (int i = 0; i < SLOTS; i++) begin
			slot_owner[i] = 0;
			slot_sell[i]  = 0;
			slot_price[i] = 0;
			slot_open[i]  = 0;
			slot_live[i]  = 0;
			free_slots[i] = SLOTS - 1 - i;
		end
		free_depth = SLOTS;
		for (int s = 0; s < 2; s++) begin
			for (int i = 0; i < LEVELS * DEPTH; i++) ring[s][i] = 0;
			for (int i = 0; i < LEVELS; i++) ring_ptrs[s][i] = 0;
			top_level[s] = NO_LEVEL;
		end
	endfunction

	// A level just lost its last order: if it was the best one, walk away
	// from the spread until a populated level turns up.
	function automatic void rescan_top(int unsigned s, int unsigned lv);
		if (top_level[s] != lv) return;
		top_level[s] = NO_LEVEL;
		if (s == 0) begin
			for (int i = int'(lv); i >= 0; i--) begin
				if (!ring_empty(0, i)) begin
					top_level[0] = i;
					return;
				end
			end
		end else begin
			for (int i = int'(lv); i < LEVELS; i++) begin
				if (!ring_empty(1, i)) begin
					top_level[1] = i;
					return;
				end
			end
		end
	endfunction

	function automatic void release_slot(int unsigned slot);
		slot_live[slot] = 0;
		slot_open[slot] = 0;
		if (free_depth < SLOTS) begin
			free_slots[free_depth] = slot;
			free_depth++;
		end
	endfunction

	function automatic void owe_word(logic kind, int unsigned taker, int unsigned maker,
		int unsigned qty, int unsigned lv, logic [2:0] st, int unsigned left);
		lobm_pkg::lobm_res_t w;
		w = '0;
		w.result_kind        = kind;
		w.taker_client       = taker;
		w.maker_client       = maker;
		w.fill_quantity      = qty[15:0];
		w.trade_level        = lv[7:0];
		w.status             = st;
		w.remaining_quantity = left[15:0];
		if (kind) begin
			w.bid_present = top_level[0] != NO_LEVEL;
			w.best_bid    = w.bid_present ? top_level[0][7:0] : 8'd0;
			w.ask_present = top_level[1] != NO_LEVEL;
			w.best_ask    = w.ask_present ? top_level[1][7:0] : 8'd0;
			w.last        = 1'b1;
			last_status   = st;
		end
		owed_words[owed_wr] = w;
		owed_wr++;
	endfunction

	// Match an incoming order against the far side, then rest, drop or cap it.
	function automatic void match_order(int unsigned taker, int unsigned s, bit priced,
		int unsigned px, int unsigned qty);
		int unsigned far_side;
		int unsigned left;
		int unsigned fills;
		int unsigned lv;
		int unsigned hd;
		int unsigned slot;
		int unsigned take;
		int unsigned tl;
		bit capped;
		logic [2:0] st;
		far_side = s ^ 1;
		left = qty;
		fills = 0;
		capped = 0;
		while (left > 0) begin
			lv = top_level[far_side];
			if (lv >= LEVELS) break;
			if (priced && (s == 0 ? lv > px : lv < px)) break;
			if (fills >= MAX_FILL) begin
				capped = 1;
				break;
			end
			if (ring_empty(far_side, lv)) begin
				rescan_top(far_side, lv);
				continue;
			end
			hd = ring_head(far_side, lv);
			slot = ring[far_side][lv * DEPTH + hd] % SLOTS;
			take = slot_open[slot] < left ? slot_open[slot] : left;
			slot_open[slot] -= take;
			left -= take;
			owe_word(1'b0, taker, slot_owner[slot], take, slot_price[slot],
				lobm_pkg::ST_FILLED, left);
			fills++;
			if (slot_open[slot] == 0) begin
				ring_ptrs[far_side][lv] = ((hd + 1) % DEPTH) * DEPTH + ring_tail(far_side, lv);
				release_slot(slot);
			end
			if (ring_empty(far_side, lv)) rescan_top(far_side, lv);
		end
		if (left == 0) st = lobm_pkg::ST_FILLED;
		else if (capped) st = lobm_pkg::ST_FILLCAP;
		else if (!priced) st = lobm_pkg::ST_NOLIQ;
		else if (free_depth == 0 || (ring_tail(s, px) + 1) % DEPTH == ring_head(s, px))
			st = lobm_pkg::ST_FULL;
		else begin
			free_depth--;
			slot = free_slots[free_depth] % SLOTS;
			tl = ring_tail(s, px);
			slot_owner[slot] = taker;
			slot_sell[slot]  = s[0];
			slot_price[slot] = px;
			slot_open[slot]  = left;
			slot_live[slot]  = 1;
			ring[s][px * DEPTH + tl] = slot;
			ring_ptrs[s][px] = ring_head(s, px) * DEPTH + (tl + 1) % DEPTH;
			if (top_level[s] == NO_LEVEL || (s == 0 ? px > top_level[s] : px < top_level[s]))
				top_level[s] = px;
			st = lobm_pkg::ST_RESTED;
		end
		owe_word(1'b1, taker, 0, 0, 0, st, left);
	endfunction

	// Take a resting order out of its ring, closing the gap behind it.
	function automatic void pull_order(int unsigned slot);
		int unsigned s;
		int unsigned lv;
		int unsigned hd;
		int unsigned tl;
		int unsigned pos;
		int unsigned end_pos;
		s = slot_sell[slot];
		lv = slot_price[slot] % LEVELS;
		hd = ring_head(s, lv);
		tl = ring_tail(s, lv);
		pos = hd;
		while (pos != tl && ring[s][lv * DEPTH + pos] != slot) pos = (pos + 1) % DEPTH;
		if (pos != tl) begin
			end_pos = (tl + DEPTH - 1) % DEPTH;
			for (int unsigned c = pos; c != end_pos; c = (c + 1) % DEPTH)
				ring[s][lv * DEPTH + c] = ring[s][lv * DEPTH + (c + 1) % DEPTH];
			ring_ptrs[s][lv] = hd * DEPTH + end_pos;
		end
		release_slot(slot);
		if (ring_empty(s, lv)) rescan_top(s, lv);
	endfunction

	// Work out every word one accepted order causes.
	function automatic void predict_order(logic [1:0] op, logic [31:0] cid, logic sd,
		logic [7:0] px, logic [15:0] qty);
		int unsigned slot;
		slot = SLOTS;
		if (op == lobm_pkg::OP_LIMIT) begin
			match_order(cid, sd, 1, px, qty);
			return;
		end
		if (op == lobm_pkg::OP_MARKET) begin
			match_order(cid, sd, 0, px, qty);
			return;
		end
		// Cancel and replace hit the lowest-numbered live slot with this id.
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_live[i] && slot_owner[i] == cid) begin
				slot = i;
				break;
			end
		end
		if (slot == SLOTS) begin
			owe_word(1'b1, cid, 0, 0, 0, lobm_pkg::ST_NOTFOUND, 0);
			return;
		end
		sd = slot_sell[slot];
		pull_order(slot);
		if (op == lobm_pkg::OP_CANCEL) owe_word(1'b1, cid, 0, 0, 0, lobm_pkg::ST_CANCELLED, 0);
		else match_order(cid, sd, 1, px, qty);
	endfunction

	// ------------------------------------------------------------------
	// Order side: bursts of back-to-back words separated by random gaps.
	// Fields change only at the falling edge; acceptance is judged at the
	// rising edge, where the prediction is made.
	// ------------------------------------------------------------------
	int unsigned burst_left;

	task automatic send_order(logic [1:0] op, logic [31:0] cid, logic sd, logic [7:0] px,
		logic [15:0] qty);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				order.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		order.valid       <= 1'b1;
		order.operation   <= op;
		order.client_id   <= cid;
		order.side        <= sd;
		order.price_level <= px;
		order.quantity    <= qty;
		do @(posedge clk); while (!order.ready);
		predict_order(op, cid, sd, px, qty);
		orders_sent++;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side: ready follows its own pattern of runs and stalls, with
	// occasional long runs that never stall.
	// ------------------------------------------------------------------
	int unsigned run_left;
	int unsigned stall_left;

	always @(negedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (stall_left > 0) begin
			result.ready <= 1'b0;
			stall_left--;
		end else if (run_left > 0) begin
			result.ready <= 1'b1;
			run_left--;
		end else begin
			result.ready <= 1'b1;
			run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 6);
			stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
		end
	end

	// Every word leaving the block is held against the oldest expectation.
	always @(posedge clk) begin
		lobm_pkg::lobm_res_t want;
		if (arst_n && result.valid && result.ready) begin
			words_seen++;
			if (owed_rd == owed_wr) begin
				$error("unexpected result word: taker %0d status %0d",
					result.taker_client, result.status);
				fail_count++;
			end else begin
				want = owed_words[owed_rd];
				owed_words.delete(owed_rd);
				owed_rd++;
				if (!result.result_kind) fills_seen++;
				else status_hits[result.status]++;
				if (result.result_kind !== want.result_kind) begin
					$error("result_kind: expected %0d, got %0d", want.result_kind,
						result.result_kind);
					fail_count++;
				end
				if (result.taker_client !== want.taker_client) begin
					$error("taker_client: expected %0d, got %0d", want.taker_client,
						result.taker_client);
					fail_count++;
				end
				if (result.maker_client !== want.maker_client) begin
					$error("maker_client: expected %0d, got %0d", want.maker_client,
						result.maker_client);
					fail_count++;
				end
				if (result.fill_quantity !== want.fill_quantity) begin
					$error("fill_quantity: expected %0d, got %0d", want.fill_quantity,
						result.fill_quantity);
					fail_count++;
				end
				if (result.trade_level !== want.trade_level) begin
					$error("trade_level: expected %0d, got %0d", want.trade_level,
						result.trade_level);
					fail_count++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					fail_count++;
				end
				if (result.remaining_quantity !== want.remaining_quantity) begin
					$error("remaining_quantity: expected %0d, got %0d",
						want.remaining_quantity, result.remaining_quantity);
					fail_count++;
				end
				if (result.best_bid !== want.best_bid) begin
					$error("best_bid: expected %0d, got %0d", want.best_bid, result.best_bid);
					fail_count++;
				end
				if (result.bid_present !== want.bid_present) begin
					$error("bid_present: expected %0d, got %0d", want.bid_present,
						result.bid_present);
					fail_count++;
				end
				if (result.best_ask !== want.best_ask) begin
					$error("best_ask: expected %0d, got %0d", want.best_ask, result.best_ask);
					fail_count++;
				end
				if (result.ask_present !== want.ask_present) begin
					$error("ask_present: expected %0d, got %0d", want.ask_present,
						result.ask_present);
					fail_count++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result.last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: a run of cycles with no word moving on either channel means
	// the block has hung.
	int unsigned quiet_cycles;

	always @(posedge clk) begin
		if ((order.valid && order.ready) || (result.valid && result.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[limit_order_book_matcher] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Directed orders. A status is typed in only where it is obvious; the
	// remaining rows rely on the model alone.
	// ------------------------------------------------------------------
	typedef struct {
		logic [1:0]  op;
		logic [31:0] cid;
		logic        sd;
		logic [7:0]  px;
		logic [15:0] qty;
		bit          known;
		logic [2:0]  st;
	} order_row_t;

	order_row_t script [21] = '{
		// Empty book: unknown id, a market order with nothing to hit, zero size.
		'{lobm_pkg::OP_CANCEL,  32'd5,        1'b0, 8'd0,   16'd1,     1'b1,
			lobm_pkg::ST_NOTFOUND},
		'{lobm_pkg::OP_REPLACE, 32'd6,        1'b1, 8'd9,   16'd9,     1'b1,
			lobm_pkg::ST_NOTFOUND},
		'{lobm_pkg::OP_MARKET,  32'd7,        1'b0, 8'd255, 16'd65535, 1'b1,
			lobm_pkg::ST_NOLIQ},
		'{lobm_pkg::OP_LIMIT,   32'd8,        1'b0, 8'd10,  16'd0,     1'b1,
			lobm_pkg::ST_FILLED},
		// Build both sides at the extremes of price and size.
		'{lobm_pkg::OP_LIMIT,   32'd10,       1'b1, 8'd255, 16'd10,    1'b1,
			lobm_pkg::ST_RESTED},
		'{lobm_pkg::OP_LIMIT,   32'd11,       1'b1, 8'd200, 16'd5,     1'b1,
			lobm_pkg::ST_RESTED},
		'{lobm_pkg::OP_LIMIT,   32'd12,       1'b1, 8'd200, 16'd7,     1'b1,
			lobm_pkg::ST_RESTED},
		'{lobm_pkg::OP_LIMIT,   32'd20,       1'b0, 8'd0,   16'd65535, 1'b1,
			lobm_pkg::ST_RESTED},
		'{lobm_pkg::OP_LIMIT,   32'd21,       1'b0, 8'd199, 16'd3,     1'b1,
			lobm_pkg::ST_RESTED},
		// Crossing buy takes the oldest ask at 200, then part of the next.
		'{lobm_pkg::OP_LIMIT,   32'd22,       1'b0, 8'd200, 16'd6,     1'b0,
			lobm_pkg::ST_FILLED},
		'{lobm_pkg::OP_REPLACE, 32'd12,       1'b0, 8'd201, 16'd4,     1'b0,
			lobm_pkg::ST_FILLED},
		'{lobm_pkg::OP_CANCEL,  32'd21,       1'b0, 8'd0,   16'd1,     1'b1,
			lobm_pkg::ST_CANCELLED},
		'{lobm_pkg::OP_CANCEL,  32'd21,       1'b0, 8'd0,   16'd1,     1'b1,
			lobm_pkg::ST_NOTFOUND},
		// Duplicate ids: the cancel removes only one of them.
		'{lobm_pkg::OP_LIMIT,   32'hFFFFFFFF, 1'b1, 8'd220, 16'd2,     1'b1,
			lobm_pkg::ST_RESTED},
		'{lobm_pkg::OP_LIMIT,   32'hFFFFFFFF, 1'b1, 8'd221, 16'd3,     1'b1,
			lobm_pkg::ST_RESTED},
		'{lobm_pkg::OP_CANCEL,  32'hFFFFFFFF, 1'b0, 8'd0,   16'd1,     1'b0,
			lobm_pkg::ST_FILLED},
		// Replace a bid into a price that crosses the asks.
		'{lobm_pkg::OP_REPLACE, 32'd20,       1'b0, 8'd221, 16'd65535, 1'b0,
			lobm_pkg::ST_FILLED},
		// Market sell sweeps whatever bids are left.
		'{lobm_pkg::OP_MARKET,  32'h80000000, 1'b1, 8'd0,   16'd65535, 1'b0,
			lobm_pkg::ST_FILLED},
		'{lobm_pkg::OP_MARKET,  32'h7FFFFFFF, 1'b0, 8'd0,   16'd65535, 1'b0,
			lobm_pkg::ST_FILLED},
		'{lobm_pkg::OP_LIMIT,   32'd23,       1'b1, 8'd1,   16'd1,     1'b1,
			lobm_pkg::ST_RESTED},
		'{lobm_pkg::OP_MARKET,  32'd24,       1'b0, 8'd128, 16'd1,     1'b1,
			lobm_pkg::ST_FILLED}
	};

	logic [1:0]  r_op;
	logic [31:0] r_cid;
	logic [7:0]  r_px;
	logic [15:0] r_qty;
	int unsigned pick;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		order.valid = 1'b0;
		order.operation = lobm_pkg::OP_LIMIT;
		order.client_id = '0;
		order.side = 1'b0;
		order.price_level = '0;
		order.quantity = '0;
		result.ready = 1'b0;
		burst_left = 0;
		run_left = 0;
		stall_left = 0;
		quiet_cycles = 0;
		fail_count = 0;
		words_seen = 0;
		fills_seen = 0;
		orders_sent = 0;
		owed_wr = 0;
		owed_rd = 0;
		foreach (status_hits[i]) status_hits[i] = 0;
		book_clear();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (script[i]) begin
			send_order(script[i].op, script[i].cid, script[i].sd, script[i].px, script[i].qty);
			if (script[i].known && last_status !== script[i].st) begin
				$error("status of row %0d: expected %0d, model gives %0d", i, script[i].st,
					last_status);
				fail_count++;
			end
		end

		// A level whose ring holds DEPTH - 1 orders is full and refuses the next order.
		for (int i = 0; i < DEPTH - 1; i++)
			send_order(lobm_pkg::OP_LIMIT, 300 + i, 1'b1, 8'd70, 16'd2);
		send_order(lobm_pkg::OP_LIMIT, 399, 1'b1, 8'd70, 16'd2);
		if (last_status !== lobm_pkg::ST_FULL) begin
			$error("status of full level: expected %0d, model gives %0d", lobm_pkg::ST_FULL,
				last_status);
			fail_count++;
		end
		// More single-lot makers than the fill cap allows, spread over levels.
		for (int i = 0; i < 65; i++)
			send_order(lobm_pkg::OP_LIMIT, 500 + i, 1'b1, 8'(60 + i / 13), 16'd1);
		send_order(lobm_pkg::OP_MARKET, 600, 1'b0, 8'd0, 16'd100);
		if (last_status !== lobm_pkg::ST_FILLCAP) begin
			$error("status of capped order: expected %0d, model gives %0d",
				lobm_pkg::ST_FILLCAP, last_status);
			fail_count++;
		end

		// Random traffic around a mid price, with a small id pool so that
		// cancels and replaces usually find their target and ids repeat.
		for (int n = 0; n < RANDOM_ORDERS; n++) begin
			pick = $urandom_range(0, 99);
			r_op = pick < 45 ? lobm_pkg::OP_LIMIT : pick < 60 ? lobm_pkg::OP_MARKET
				: pick < 80 ? lobm_pkg::OP_CANCEL : lobm_pkg::OP_REPLACE;
			r_cid = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 47);
			r_px = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(110, 140));
			pick = $urandom_range(0, 19);
			r_qty = pick == 0 ? 16'($urandom_range(1, 65535)) : pick == 1 ? 16'hFFFF
				: 16'($urandom_range(1, 60));
			send_order(r_op, r_cid, 1'($urandom_range(0, 1)), r_px, r_qty);
		end
		order.valid <= 1'b0;

		wait (owed_rd == owed_wr);
		repeat (200) @(posedge clk);
		$display("Sent %0d orders; checked %0d result words, %0d of them fills.",
			orders_sent, words_seen, fills_seen);
		$display("Statuses: filled %0d, rested %0d, no liquidity %0d, full %0d, cap %0d,",
			status_hits[lobm_pkg::ST_FILLED], status_hits[lobm_pkg::ST_RESTED],
			status_hits[lobm_pkg::ST_NOLIQ], status_hits[lobm_pkg::ST_FULL],
			status_hits[lobm_pkg::ST_FILLCAP]);
		$display("  cancelled %0d, not found %0d.", status_hits[lobm_pkg::ST_CANCELLED],
			status_hits[lobm_pkg::ST_NOTFOUND]);
		if (fail_count == 0 && owed_rd == owed_wr) begin
			$display("[limit_order_book_matcher] OK");
		end else begin
			$display("[limit_order_book_matcher] ERROR");
		end
		$finish;
	end

endmodule
